### hdl/touch_gesture_classifier_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the touch gesture checker
// ---------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_CLASSIFIER_UNIT_MACROS_SVH
`define TOUCH_GESTURE_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, quiet while reset is high
`define TGC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tgc assertion failed");

// Next-cycle implication, quiet while reset is high
`define TGC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tgc assertion failed");

// Next-cycle implication that also checks across reset
`define TGC_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("tgc assertion failed");

`endif

### hdl/tgc_pkg.sv
// ---------------------------------------------------------------------------
// tgc_pkg
// Types, constants and helpers of the touch gesture classifier.
// ---------------------------------------------------------------------------
package tgc_pkg;

   localparam int unsigned MAX_TOUCHES = 5;

   localparam int unsigned COUNT_W = 4;
   localparam int unsigned COORD_W = 16;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned KIND_W  = 3;
   localparam int unsigned CSR_W   = 16;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned SQ_W    = 2 * COORD_W;

   localparam int unsigned REQ_ITEM_W  = COUNT_W + 2 * COORD_W + TIME_W;
   localparam int unsigned REQ_TDATA_W = ((REQ_ITEM_W + 7) / 8) * 8;
   localparam int unsigned RSP_ITEM_W  = KIND_W + 4 * COORD_W + TIME_W;
   localparam int unsigned RSP_TDATA_W = ((RSP_ITEM_W + 7) / 8) * 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_SWIPE_RIGHT = 3'd0,
      KIND_SWIPE_LEFT  = 3'd1,
      KIND_SWIPE_DOWN  = 3'd2,
      KIND_SWIPE_UP    = 3'd3,
      KIND_DOUBLE_TAP  = 3'd4
   } gesture_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SWIPE_MAX_DURATION = 3'd0,
      CSR_SWIPE_MIN_DISTANCE = 3'd1,
      CSR_TAP_MAX_DURATION   = 3'd2,
      CSR_TAP_MAX_MOVEMENT   = 3'd3,
      CSR_DTAP_INTERVAL      = 3'd4,
      CSR_DTAP_MAX_DISTANCE  = 3'd5
   } csr_index_type;

   localparam logic [CSR_W-1:0] RST_SWIPE_MAX_DURATION = 16'd500;
   localparam logic [CSR_W-1:0] RST_SWIPE_MIN_DISTANCE = 16'd50;
   localparam logic [CSR_W-1:0] RST_TAP_MAX_DURATION   = 16'd200;
   localparam logic [CSR_W-1:0] RST_TAP_MAX_MOVEMENT   = 16'd20;
   localparam logic [CSR_W-1:0] RST_DTAP_INTERVAL      = 16'd300;
   localparam logic [CSR_W-1:0] RST_DTAP_MAX_DISTANCE  = 16'd40;
   localparam logic [SQ_W-1:0]  RST_DTAP_MAX_DIST_SQ   = 32'd1600;

   // Input item, last field in the lowest bits
   typedef struct packed {
      logic [TIME_W-1:0]  now_ms;
      logic [COORD_W-1:0] point_y;
      logic [COORD_W-1:0] point_x;
      logic [COUNT_W-1:0] touch_count;
   } req_item_type;

   // Result item, last field in the lowest bits
   typedef struct packed {
      logic [TIME_W-1:0]  elapsed_ms;
      logic [COORD_W-1:0] finish_y;
      logic [COORD_W-1:0] finish_x;
      logic [COORD_W-1:0] begin_y;
      logic [COORD_W-1:0] begin_x;
      gesture_kind_type   gesture_kind;
   } rsp_item_type;

   typedef struct packed {
      logic [CSR_W-1:0] swipe_dur_max;
      logic [CSR_W-1:0] swipe_dist_min;
      logic [CSR_W-1:0] tap_dur_max;
      logic [CSR_W-1:0] tap_move_max;
      logic [CSR_W-1:0] double_tap_interval_ms;
      logic [SQ_W-1:0]  double_tap_max_dist_sq;
   } cfg_type;

   typedef struct packed {
      logic         fire;
      rsp_item_type item;
   } result_type;

   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      abs_diff = (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

### hdl/tgc_core.sv
// ---------------------------------------------------------------------------
// tgc_core
// Touch tracking state and release classification for one report per step.
// ---------------------------------------------------------------------------
module tgc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  tgc_pkg::req_item_type item,
   input  tgc_pkg::cfg_type      cfg,
   output tgc_pkg::result_type   result
);

   logic                         touch_active_ff, touch_active_in;
   logic                         ignore_touch_ff, ignore_touch_in;
   logic [tgc_pkg::TIME_W-1:0]   start_time_ff, start_time_in;
   logic [tgc_pkg::COORD_W-1:0]  start_x_ff, start_x_in;
   logic [tgc_pkg::COORD_W-1:0]  start_y_ff, start_y_in;
   logic [tgc_pkg::COORD_W-1:0]  recent_x_ff, recent_x_in;
   logic [tgc_pkg::COORD_W-1:0]  recent_y_ff, recent_y_in;
   logic [tgc_pkg::TIME_W-1:0]   tap_time_ff, tap_time_in;
   logic [tgc_pkg::COORD_W-1:0]  tap_x_ff, tap_x_in;
   logic [tgc_pkg::COORD_W-1:0]  tap_y_ff, tap_y_in;
   // squared axis distances between touch start and pending tap start
   logic [tgc_pkg::SQ_W-1:0]     dsq_x_ff, dsq_x_in;
   logic [tgc_pkg::SQ_W-1:0]     dsq_y_ff, dsq_y_in;

   logic [tgc_pkg::COORD_W-1:0]  adx, ady, maxmove, tdx, tdy;
   logic [tgc_pkg::TIME_W-1:0]   dur, tap_age;
   logic [tgc_pkg::SQ_W:0]       dsq_sum;
   logic                         is_invalid, is_release, swipe_hit, tap_hit, tap_live;
   logic                         dbl_hit;
   tgc_pkg::gesture_kind_type    swipe_kind;

   always_comb begin
      is_invalid = item.touch_count > tgc_pkg::COUNT_W'(tgc_pkg::MAX_TOUCHES);
      is_release = item.touch_count == '0;
      adx        = tgc_pkg::abs_diff(recent_x_ff, start_x_ff);
      ady        = tgc_pkg::abs_diff(recent_y_ff, start_y_ff);
      maxmove    = (adx > ady) ? adx : ady;
      dur        = item.now_ms - start_time_ff;
      tap_age    = item.now_ms - tap_time_ff;
      tap_live   = (tap_time_ff != '0) &&
                   (tap_age <= {16'b0, cfg.double_tap_interval_ms});
      dsq_sum    = {1'b0, dsq_x_ff} + {1'b0, dsq_y_ff};
      swipe_hit  = (dur <= {16'b0, cfg.swipe_dur_max}) &&
                   ((adx >= cfg.swipe_dist_min) || (ady >= cfg.swipe_dist_min));
      tap_hit    = (dur <= {16'b0, cfg.tap_dur_max}) &&
                   (maxmove <= cfg.tap_move_max);
      dbl_hit    = tap_live && (dsq_sum <= {1'b0, cfg.double_tap_max_dist_sq});
      if (adx >= ady) begin
         swipe_kind = (recent_x_ff >= start_x_ff) ? tgc_pkg::KIND_SWIPE_RIGHT
                                                  : tgc_pkg::KIND_SWIPE_LEFT;
      end else begin
         swipe_kind = (recent_y_ff >= start_y_ff) ? tgc_pkg::KIND_SWIPE_DOWN
                                                  : tgc_pkg::KIND_SWIPE_UP;
      end
      // distance from a new touch start to the pending tap start
      tdx = tgc_pkg::abs_diff(item.point_x, tap_x_ff);
      tdy = tgc_pkg::abs_diff(item.point_y, tap_y_ff);
   end

   always_comb begin
      touch_active_in = touch_active_ff;
      ignore_touch_in = ignore_touch_ff;
      start_time_in   = start_time_ff;
      start_x_in      = start_x_ff;
      start_y_in      = start_y_ff;
      recent_x_in     = recent_x_ff;
      recent_y_in     = recent_y_ff;
      tap_time_in     = tap_time_ff;
      tap_x_in        = tap_x_ff;
      tap_y_in        = tap_y_ff;
      dsq_x_in        = dsq_x_ff;
      dsq_y_in        = dsq_y_ff;

      result.fire              = 1'b0;
      result.item.gesture_kind = swipe_kind;
      result.item.begin_x      = start_x_ff;
      result.item.begin_y      = start_y_ff;
      result.item.finish_x     = recent_x_ff;
      result.item.finish_y     = recent_y_ff;
      result.item.elapsed_ms   = dur;

      if (is_invalid) begin
         ignore_touch_in = 1'b1;
      end else if (!is_release) begin
         if (!touch_active_ff) begin
            start_time_in   = item.now_ms;
            start_x_in      = item.point_x;
            start_y_in      = item.point_y;
            touch_active_in = 1'b1;
            ignore_touch_in = item.touch_count != tgc_pkg::COUNT_W'(1);
            dsq_x_in        = tgc_pkg::SQ_W'(tdx) * tgc_pkg::SQ_W'(tdx);
            dsq_y_in        = tgc_pkg::SQ_W'(tdy) * tgc_pkg::SQ_W'(tdy);
         end else if (item.touch_count != tgc_pkg::COUNT_W'(1)) begin
            ignore_touch_in = 1'b1;
         end
         recent_x_in = item.point_x;
         recent_y_in = item.point_y;
      end else if (touch_active_ff) begin
         touch_active_in = 1'b0;
         ignore_touch_in = 1'b0;
         if (!ignore_touch_ff) begin
            if (swipe_hit) begin
               result.fire = 1'b1;
               tap_time_in = '0;
            end else if (tap_hit && dbl_hit) begin
               result.fire              = 1'b1;
               result.item.gesture_kind = tgc_pkg::KIND_DOUBLE_TAP;
               result.item.finish_x     = start_x_ff;
               result.item.finish_y     = start_y_ff;
               tap_time_in              = '0;
            end else if (tap_hit) begin
               // hold as pending tap; its start equals the touch start now
               tap_time_in = item.now_ms;
               tap_x_in    = start_x_ff;
               tap_y_in    = start_y_ff;
               dsq_x_in    = '0;
               dsq_y_in    = '0;
            end else begin
               tap_time_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touch_active_ff <= 1'b0;
         ignore_touch_ff <= 1'b0;
         tap_time_ff     <= '0;
      end else if (step_en) begin
         touch_active_ff <= touch_active_in;
         ignore_touch_ff <= ignore_touch_in;
         tap_time_ff     <= tap_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         start_time_ff <= start_time_in;
         start_x_ff    <= start_x_in;
         start_y_ff    <= start_y_in;
         recent_x_ff   <= recent_x_in;
         recent_y_ff   <= recent_y_in;
         tap_x_ff      <= tap_x_in;
         tap_y_ff      <= tap_y_in;
         dsq_x_ff      <= dsq_x_in;
         dsq_y_ff      <= dsq_y_in;
      end
   end

endmodule

### hdl/touch_gesture_classifier_unit.sv
// ---------------------------------------------------------------------------
// touch_gesture_classifier_unit
// Turns touch-controller reports into swipe and double-tap gestures.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one touch report per transaction. A report with count 1..5
//   starts or updates a touch, a count of 0 releases it. A release can yield
//   one gesture transaction on rsp_* (swipe in four directions or double
//   tap); single taps are held internally and produce nothing.
//   csr_* writes one of six 16-bit thresholds per cycle with csr_we high.
//   Write them only while no report is in flight.
// Throughput: one report per cycle, sustained while rsp_tready stays high.
// Path: an accepted report is held in the input register, then one pass of
//   compare logic puts its gesture into the result register.
// Stall: the result register holds a gesture until rsp_tready; meanwhile one
//   more report waits in the input register, then req_tready drops.
// Reset: synchronous, active high. Clears the touch and pending tap, empties
//   both registers and restores the default thresholds.
// ---------------------------------------------------------------------------
module touch_gesture_classifier_unit (
   input  logic                              clock,
   input  logic                              reset,
   // touch_count[3:0], point_x[19:4], point_y[35:20], now_ms[67:36], zero pad
   input  logic [tgc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // gesture_kind[2:0], begin_x[18:3], begin_y[34:19], finish_x[50:35],
   // finish_y[66:51], elapsed_ms[98:67], zero pad
   output logic [tgc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [tgc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tgc_pkg::CSR_W-1:0]         csr_wdata
);

   logic                  in_valid_ff, in_valid_in;
   tgc_pkg::req_item_type in_item_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   tgc_pkg::rsp_item_type rsp_item_ff;
   tgc_pkg::cfg_type      cfg_ff, cfg_in;
   tgc_pkg::result_type   result;
   logic                  advance;
   logic                  req_take;

   // Advance the held report whenever the result register is free or draining
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = (advance && result.fire) || (rsp_valid_ff && !rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(tgc_pkg::RSP_TDATA_W - tgc_pkg::RSP_ITEM_W)'(0), rsp_item_ff};

   tgc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   // Register writes; the distance limit is kept squared for the double-tap check
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (tgc_pkg::csr_index_type'(csr_index))
            tgc_pkg::CSR_SWIPE_MAX_DURATION: cfg_in.swipe_dur_max          = csr_wdata;
            tgc_pkg::CSR_SWIPE_MIN_DISTANCE: cfg_in.swipe_dist_min         = csr_wdata;
            tgc_pkg::CSR_TAP_MAX_DURATION:   cfg_in.tap_dur_max            = csr_wdata;
            tgc_pkg::CSR_TAP_MAX_MOVEMENT:   cfg_in.tap_move_max           = csr_wdata;
            tgc_pkg::CSR_DTAP_INTERVAL:      cfg_in.double_tap_interval_ms = csr_wdata;
            tgc_pkg::CSR_DTAP_MAX_DISTANCE:  cfg_in.double_tap_max_dist_sq =
                                                tgc_pkg::SQ_W'(csr_wdata) *
                                                tgc_pkg::SQ_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff.swipe_dur_max          <= tgc_pkg::RST_SWIPE_MAX_DURATION;
         cfg_ff.swipe_dist_min         <= tgc_pkg::RST_SWIPE_MIN_DISTANCE;
         cfg_ff.tap_dur_max            <= tgc_pkg::RST_TAP_MAX_DURATION;
         cfg_ff.tap_move_max           <= tgc_pkg::RST_TAP_MAX_MOVEMENT;
         cfg_ff.double_tap_interval_ms <= tgc_pkg::RST_DTAP_INTERVAL;
         cfg_ff.double_tap_max_dist_sq <= tgc_pkg::RST_DTAP_MAX_DIST_SQ;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers: load on a new transaction, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_tdata[tgc_pkg::REQ_ITEM_W-1:0];
      end
      if (advance && result.fire) begin
         rsp_item_ff <= result.item;
      end
   end

endmodule

### hdl/tgc_checker.sv
// ---------------------------------------------------------------------------
// tgc_checker
// Port-level checks of the touch gesture classifier, bound to the top level.
// ---------------------------------------------------------------------------
`include "touch_gesture_classifier_unit_macros.svh"

module tgc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tgc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   tgc_pkg::rsp_item_type rsp_item;

   assign rsp_item = rsp_tdata[tgc_pkg::RSP_ITEM_W-1:0];

   // a stalled result transaction holds
   `TGC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // reset empties the result register
   `TGC_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_tvalid)
   // only defined gesture codes leave the block
   `TGC_ASSERT_IMPL(a_kind_range, rsp_tvalid, rsp_item.gesture_kind <= tgc_pkg::KIND_DOUBLE_TAP)
   // a double tap reports its start point as finish point
   `TGC_ASSERT_IMPL(a_dtap_point,
      rsp_tvalid && (rsp_item.gesture_kind == tgc_pkg::KIND_DOUBLE_TAP),
      (rsp_item.finish_x == rsp_item.begin_x) && (rsp_item.finish_y == rsp_item.begin_y))
   // a right swipe never moves left
   `TGC_ASSERT_IMPL(a_right_dir,
      rsp_tvalid && (rsp_item.gesture_kind == tgc_pkg::KIND_SWIPE_RIGHT),
      rsp_item.finish_x >= rsp_item.begin_x)

endmodule

bind touch_gesture_classifier_unit tgc_checker u_tgc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
